FILE: rtl/core/dtsp_pkg.sv
// ---------------------------------------------------------------------------
// DER TLV stream parser package
// Shared widths, codes and state types for the DER TLV stream parser.
// ---------------------------------------------------------------------------
package dtsp_pkg;

    // Nesting and offset sizing
    localparam int MAX_DEPTH   = 8;
    localparam int OFFSET_BITS = 32;
    localparam int SP_W        = $clog2(MAX_DEPTH + 1);
    localparam int IDX_W       = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    // Fixed field widths
    localparam int LEN_W   = 64;
    localparam int DEPTH_W = 4;
    localparam int CLOSE_W = 4;
    localparam int OCTS_W  = 4;

    localparam logic [OFFSET_BITS-1:0] OFF_MASK = '1;

    // Identifier and length octet fields
    localparam int         ID_CONS_BIT  = 5;
    localparam int         LEN_LONG_BIT = 7;
    localparam logic [6:0] LEN_RESERVED = 7'h7F;
    localparam logic [6:0] LEN_MAX_OCTS = 7'd8;

    typedef enum logic [1:0] {
        PH_ID      = 2'd0,
        PH_LEN1    = 2'd1,
        PH_LONG    = 2'd2,
        PH_CONTENT = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ROLE_ID      = 2'd0,
        ROLE_LEN     = 2'd1,
        ROLE_CONTENT = 2'd2,
        ROLE_DROP    = 2'd3
    } t_role;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_RESERVED = 3'd1,
        ERR_OCTETS   = 3'd2,
        ERR_DEEP     = 3'd3,
        ERR_OVERRUN  = 3'd4,
        ERR_TRUNC    = 3'd5
    } t_err;

    // Parser state outside the level stack
    typedef struct packed {
        t_phase                  phase;
        logic [OFFSET_BITS-1:0]  pos;
        logic [LEN_W-1:0]        acc;
        logic [OCTS_W-1:0]       octs;
        logic [7:0]              ident;
        logic [LEN_W-1:0]        elem_end;
        logic                    err;
    } t_state;

    localparam t_state ST_RESET = '{
        phase:    PH_ID,
        pos:      '0,
        acc:      '0,
        octs:     '0,
        ident:    '0,
        elem_end: '0,
        err:      1'b0
    };

    // Level stack command and status
    typedef struct packed {
        logic             upd;
        logic             clear;
        logic             push;
        logic [LEN_W-1:0] push_end;
        logic [SP_W-1:0]  pop_cnt;
    } t_stk_cmd;

    typedef struct packed {
        logic [SP_W-1:0]  sp;
        logic [LEN_W-1:0] top;
        logic [SP_W-1:0]  close_cnt;
    } t_stk_stat;

    // One result item
    typedef struct packed {
        t_role              role;
        logic [1:0]         tag_class;
        logic               cons;
        logic [4:0]         tag;
        logic [DEPTH_W-1:0] depth;
        logic               hd;
        logic [LEN_W-1:0]   clen;
        logic [CLOSE_W-1:0] closed;
        t_err               err;
        logic               buf_end;
    } t_result;

endpackage

FILE: rtl/core/dtsp_level_stack.sv
// ---------------------------------------------------------------------------
// DER TLV level stack
// Holds the end offsets of open constructed elements and counts how many of
// them end at a given offset.
// ---------------------------------------------------------------------------
module dtsp_level_stack (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dtsp_pkg::t_stk_cmd           i_cmd,
    input  logic [dtsp_pkg::LEN_W-1:0]   i_close_end,
    output dtsp_pkg::t_stk_stat          o_stat
);
    import dtsp_pkg::*;

    logic [LEN_W-1:0]     r_ends [MAX_DEPTH];
    logic [SP_W-1:0]      r_sp;
    logic [SP_W-1:0]      n_sp;
    logic [SP_W-1:0]      sp_m1;
    logic [MAX_DEPTH-1:0] hit;
    logic [SP_W-1:0]      close_cnt;
    logic                 run;

    assign sp_m1 = r_sp - SP_W'(1);

    // Compare every entry against the closing offset
    always_comb begin
        for (int k = 0; k < MAX_DEPTH; k++) begin
            hit[k] = (r_ends[k] == i_close_end);
        end
    end

    // Count the run of matching entries from the top downward
    always_comb begin
        run       = 1'b1;
        close_cnt = '0;
        for (int k = MAX_DEPTH - 1; k >= 0; k--) begin
            if (SP_W'(k) < r_sp) begin
                if (run && hit[k]) begin
                    close_cnt = close_cnt + SP_W'(1);
                end else begin
                    run = 1'b0;
                end
            end
        end
    end

    assign o_stat.sp        = r_sp;
    assign o_stat.top       = r_ends[sp_m1[IDX_W-1:0]];
    assign o_stat.close_cnt = close_cnt;

    // Next stack pointer
    always_comb begin
        priority if (i_cmd.clear) begin
            n_sp = '0;
        end else if (i_cmd.push) begin
            n_sp = r_sp + SP_W'(1);
        end else begin
            n_sp = r_sp - i_cmd.pop_cnt;
        end
    end

    // Hold the stack pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
        end else if (i_cmd.upd) begin
            r_sp <= n_sp;
        end
    end

    // Write a new end offset on push
    always_ff @(posedge i_clk) begin
        if (i_cmd.upd && i_cmd.push && !i_cmd.clear) begin
            r_ends[r_sp[IDX_W-1:0]] <= i_cmd.push_end;
        end
    end

endmodule

FILE: rtl/core/dtsp_decode.sv
// ---------------------------------------------------------------------------
// DER TLV byte decode
// Decodes one byte against the parser state: role, header and length
// decoding, bounds checks, stack command and next state.
// ---------------------------------------------------------------------------
module dtsp_decode (
    input  logic                         i_byte_valid,
    input  logic [7:0]                   i_byte,
    input  logic                         i_last,
    input  dtsp_pkg::t_state             i_st,
    input  dtsp_pkg::t_stk_stat          i_stk,
    output logic [dtsp_pkg::LEN_W-1:0]   o_close_end,
    output dtsp_pkg::t_stk_cmd           o_cmd,
    output dtsp_pkg::t_state             o_st,
    output dtsp_pkg::t_result            o_res
);
    import dtsp_pkg::*;

    logic                   sp_zero;
    logic [OFFSET_BITS-1:0] p;
    logic [LEN_W-1:0]       top_v;
    logic [LEN_W-1:0]       p1;
    logic [LEN_W-1:0]       room;
    logic [LEN_W-1:0]       acc_sh;
    logic [OCTS_W-1:0]      octs_m1;
    logic                   over;
    logic [7:0]             ident_cur;

    logic                   fin;
    logic [LEN_W-1:0]       len;
    logic [LEN_W-1:0]       new_end;
    t_err                   err;
    t_role                  role;
    logic                   hd;
    logic [LEN_W-1:0]       clen;
    logic [CLOSE_W-1:0]     closed;
    logic [CLOSE_W-1:0]     close_all;
    logic [SP_W-1:0]        sp_after;

    // Offsets seen by this byte
    assign sp_zero = (i_stk.sp == '0);
    assign p       = (i_st.phase == PH_ID && sp_zero) ? '0 : i_st.pos;
    assign top_v   = sp_zero ? LEN_W'(OFF_MASK) : i_stk.top;
    assign p1      = LEN_W'(p) + LEN_W'(1);
    assign room    = top_v - p1;
    assign over    = !sp_zero && (LEN_W'(p) >= top_v);
    assign acc_sh  = {i_st.acc[LEN_W-9:0], i_byte};
    assign octs_m1 = i_st.octs - OCTS_W'(1);
    assign new_end = p1 + len;
    assign close_all = CLOSE_W'(i_stk.close_cnt) + CLOSE_W'(1);

    assign ident_cur   = (i_st.phase == PH_ID) ? i_byte : i_st.ident;
    assign o_close_end = p1;

    always_comb begin
        o_st   = i_st;
        o_cmd  = '0;
        fin    = 1'b0;
        len    = '0;
        err    = ERR_NONE;
        role   = ROLE_ID;
        hd     = 1'b0;
        clen   = '0;
        closed = '0;

        // Per-phase byte handling
        unique case (i_st.phase)
            PH_ID: begin
                o_st.ident = i_byte;
                o_st.phase = PH_LEN1;
            end
            PH_LEN1: begin
                role = ROLE_LEN;
                if (over) begin
                    err = ERR_OVERRUN;
                end else if (!i_byte[LEN_LONG_BIT]) begin
                    fin = 1'b1;
                    len = LEN_W'(i_byte);
                end else if (i_byte[6:0] == LEN_RESERVED) begin
                    err = ERR_RESERVED;
                end else if (i_byte[6:0] > LEN_MAX_OCTS) begin
                    err = ERR_OCTETS;
                end else if (i_byte[6:0] == '0) begin
                    fin = 1'b1;
                end else begin
                    o_st.octs  = i_byte[OCTS_W-1:0];
                    o_st.acc   = '0;
                    o_st.phase = PH_LONG;
                end
            end
            PH_LONG: begin
                role = ROLE_LEN;
                if (over) begin
                    err = ERR_OVERRUN;
                end else begin
                    o_st.acc  = acc_sh;
                    o_st.octs = octs_m1;
                    if (octs_m1 == '0) begin
                        fin = 1'b1;
                        len = acc_sh;
                    end
                end
            end
            PH_CONTENT: begin
                role = ROLE_CONTENT;
                if (p1 == i_st.elem_end) begin
                    closed        = close_all;
                    o_cmd.pop_cnt = i_stk.close_cnt;
                    o_st.phase    = PH_ID;
                end
            end
        endcase

        // Header complete: check room and open, close or enter content
        if (fin && err == ERR_NONE) begin
            hd   = 1'b1;
            clen = len;
            if (len > room) begin
                err = ERR_OVERRUN;
            end else if (len == '0) begin
                closed        = close_all;
                o_cmd.pop_cnt = i_stk.close_cnt;
                o_st.phase    = PH_ID;
            end else if (i_st.ident[ID_CONS_BIT]) begin
                if (i_stk.sp >= SP_W'(MAX_DEPTH)) begin
                    err = ERR_DEEP;
                end else begin
                    o_cmd.push     = 1'b1;
                    o_cmd.push_end = new_end;
                    o_st.phase     = PH_ID;
                end
            end else begin
                o_st.elem_end = new_end;
                o_st.phase    = PH_CONTENT;
            end
        end

        // Flag truncation on the last byte
        sp_after = i_stk.sp + SP_W'(o_cmd.push) - o_cmd.pop_cnt;
        if (err == ERR_NONE && i_last && (o_st.phase != PH_ID || sp_after != '0)) begin
            err = ERR_TRUNC;
        end

        // Drop results of an error byte and latch the error
        if (err != ERR_NONE) begin
            hd       = 1'b0;
            clen     = '0;
            closed   = '0;
            o_st.err = 1'b1;
        end

        o_st.pos = p1[OFFSET_BITS-1:0];

        o_res.role      = role;
        o_res.tag_class = ident_cur[7:6];
        o_res.cons      = ident_cur[ID_CONS_BIT];
        o_res.tag       = ident_cur[4:0];
        o_res.depth     = DEPTH_W'(i_stk.sp);
        o_res.hd        = hd;
        o_res.clen      = clen;
        o_res.closed    = closed;
        o_res.err       = err;
        o_res.buf_end   = i_last;

        // Discard bytes after an error
        if (i_st.err) begin
            o_st          = i_st;
            o_cmd         = '0;
            o_res         = '0;
            o_res.role    = ROLE_DROP;
            o_res.err     = ERR_NONE;
            o_res.buf_end = i_last;
        end

        // Return to reset state after the buffer end
        if (i_last) begin
            o_st        = ST_RESET;
            o_cmd.clear = 1'b1;
            o_cmd.push  = 1'b0;
        end

        o_cmd.upd = i_byte_valid;
    end

endmodule

FILE: rtl/core/der_tlv_stream_parser.sv
// ---------------------------------------------------------------------------
// DER TLV stream parser
// Parses a DER byte stream one byte per item and gives one result item per
// byte: byte role, element identifier fields, depth, lengths and errors.
// ---------------------------------------------------------------------------
//
//  Channel | Handshake                  | Payload
//  --------+----------------------------+------------------------------------
//  input   | i_in_valid / o_in_ready    | i_data_byte, i_last_byte
//  output  | o_out_valid / i_out_ready  | o_byte_role .. o_buffer_end
//
//  One byte per clock sustained while the output is not stalled. A byte sits
//  in the input register, is decoded against the parser state and level
//  stack in a single pass, and its result is registered in the output register.
//  A stalled output holds its result; the input register keeps filling until
//  both registers are full, then o_in_ready drops.
//  Synchronous active-low reset clears the parser state and both valids.
//
module der_tlv_stream_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_byte_role,
    output logic [1:0]  o_tag_class,
    output logic        o_is_constructed,
    output logic [4:0]  o_tag_number,
    output logic [3:0]  o_nest_depth,
    output logic        o_header_done,
    output logic [63:0] o_content_length,
    output logic [3:0]  o_levels_closed,
    output logic [2:0]  o_error_code,
    output logic        o_buffer_end
);
    import dtsp_pkg::*;

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_last;
    logic             r_out_valid;
    t_result          r_res;
    t_state           r_st;

    t_state           n_st;
    t_result          n_res;
    t_stk_cmd         stk_cmd;
    t_stk_stat        stk_stat;
    logic [LEN_W-1:0] close_end;
    logic             adv;

    // Move a byte from the input register into the result register
    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    dtsp_decode u_decode (
        .i_byte_valid (adv),
        .i_byte       (r_in_byte),
        .i_last       (r_in_last),
        .i_st         (r_st),
        .i_stk        (stk_stat),
        .o_close_end  (close_end),
        .o_cmd        (stk_cmd),
        .o_st         (n_st),
        .o_res        (n_res)
    );

    dtsp_level_stack u_stack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (stk_cmd),
        .i_close_end  (close_end),
        .o_stat       (stk_stat)
    );

    // Valids and parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_st        <= ST_RESET;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                r_st        <= n_st;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture input item and result payload
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
        if (adv) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_byte_role      = r_res.role;
    assign o_tag_class      = r_res.tag_class;
    assign o_is_constructed = r_res.cons;
    assign o_tag_number     = r_res.tag;
    assign o_nest_depth     = r_res.depth;
    assign o_header_done    = r_res.hd;
    assign o_content_length = r_res.clen;
    assign o_levels_closed  = r_res.closed;
    assign o_error_code     = r_res.err;
    assign o_buffer_end     = r_res.buf_end;

endmodule

FILE: tb/testbench.sv
// ---------------------------------------------------------------------------
// DER TLV stream parser testbench
// Sends directed and random DER buffers one byte per item, predicts each
// result item with a cycle-free parser of its own and checks every field of
// every result in order, with random sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
module testbench;

    import dtsp_pkg::*;

    localparam int RANDOM_ITEMS   = 820;
    localparam int PRESSURE_ITEMS = 80;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PRINT_LIMIT    = 40;

    typedef logic [7:0] t_byte_q [$];

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte  = 8'h00;
    logic        i_last_byte  = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready  = 1'b0;
    logic [1:0]  o_byte_role;
    logic [1:0]  o_tag_class;
    logic        o_is_constructed;
    logic [4:0]  o_tag_number;
    logic [3:0]  o_nest_depth;
    logic        o_header_done;
    logic [63:0] o_content_length;
    logic [3:0]  o_levels_closed;
    logic [2:0]  o_error_code;
    logic        o_buffer_end;

    // Parser state mirrored for prediction
    t_phase      ps_phase;
    logic [63:0] ps_pos;
    logic [63:0] ps_level_end [MAX_DEPTH];
    int          ps_sp;
    logic [63:0] ps_len_acc;
    logic [3:0]  ps_len_left;
    logic [7:0]  ps_ident;
    logic [63:0] ps_elem_end;
    logic        ps_failed;

    t_result     pending_results [$];
    int          error_count = 0;
    int          result_count = 0;
    int          burst_left = 0;
    int          idle_cycles = 0;
    int          hold_req = 0;
    int          hold_ack = 0;
    int          hold_left = 0;
    logic [7:0]  stall_phase = 8'h00;
    int          stall_mode = 0;

    der_tlv_stream_parser DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_byte_role      (o_byte_role),
        .o_tag_class      (o_tag_class),
        .o_is_constructed (o_is_constructed),
        .o_tag_number     (o_tag_number),
        .o_nest_depth     (o_nest_depth),
        .o_header_done    (o_header_done),
        .o_content_length (o_content_length),
        .o_levels_closed  (o_levels_closed),
        .o_error_code     (o_error_code),
        .o_buffer_end     (o_buffer_end)
    );

    always #10 i_clk = ~i_clk;

    // -----------------------------------------------------------------------
    // Prediction
    // -----------------------------------------------------------------------

    function automatic void reset_parser();
        ps_phase    = PH_ID;
        ps_pos      = '0;
        ps_sp       = 0;
        ps_len_acc  = '0;
        ps_len_left = '0;
        ps_ident    = '0;
        ps_elem_end = '0;
        ps_failed   = 1'b0;
        foreach (ps_level_end[i]) ps_level_end[i] = '0;
    endfunction

    // Pop every open level that ends at the given offset
    function automatic int close_levels_at(input logic [63:0] end_off);
        int n;
        n = 0;
        while (ps_sp > 0 && ps_level_end[ps_sp-1] == end_off) begin
            ps_sp--;
            n++;
        end
        return n;
    endfunction

    function automatic t_result parse_byte(input logic [7:0] b, input logic l);
        t_result     r;
        logic [63:0] msk, p, top, len, room, clen;
        int          depth, closed;
        t_err        err;
        t_role       role;
        logic        fin, hd;
        r = '0;
        msk = 64'(OFF_MASK);
        // After an error, drop bytes until the buffer ends
        if (ps_failed) begin
            r.role = ROLE_DROP;
            r.buf_end = l;
            if (l) reset_parser();
            return r;
        end
        depth  = ps_sp;
        p      = ps_pos & msk;
        top    = (ps_sp > 0) ? ps_level_end[ps_sp-1] : msk;
        err    = ERR_NONE;
        role   = ROLE_DROP;
        fin    = 1'b0;
        hd     = 1'b0;
        len    = '0;
        clen   = '0;
        closed = 0;
        case (ps_phase)
            PH_ID: begin
                if (ps_sp == 0) begin
                    p = '0;
                    top = msk;
                end
                ps_ident = b;
                role = ROLE_ID;
                ps_phase = PH_LEN1;
            end
            PH_LEN1: begin
                role = ROLE_LEN;
                if (ps_sp > 0 && p >= top) begin
                    err = ERR_OVERRUN;
                end else if (!b[LEN_LONG_BIT]) begin
                    fin = 1'b1;
                    len = 64'(b);
                end else if (b[6:0] == LEN_RESERVED) begin
                    err = ERR_RESERVED;
                end else if (b[6:0] > LEN_MAX_OCTS) begin
                    err = ERR_OCTETS;
                end else if (b[6:0] == 7'd0) begin
                    fin = 1'b1;
                end else begin
                    ps_len_left = OCTS_W'(b[6:0]);
                    ps_len_acc = '0;
                    ps_phase = PH_LONG;
                end
            end
            PH_LONG: begin
                role = ROLE_LEN;
                if (ps_sp > 0 && p >= top) begin
                    err = ERR_OVERRUN;
                end else begin
                    ps_len_acc = {ps_len_acc[55:0], b};
                    ps_len_left = ps_len_left - 1'b1;
                    if (ps_len_left == '0) begin
                        fin = 1'b1;
                        len = ps_len_acc;
                    end
                end
            end
            default: begin
                role = ROLE_CONTENT;
                if (p + 1 == ps_elem_end) begin
                    closed = 1 + close_levels_at(p + 1);
                    ps_phase = PH_ID;
                end
            end
        endcase

        // Header complete: open a level, enter content, or close right away
        if (fin && err == ERR_NONE) begin
            room = top - (p + 1);
            hd = 1'b1;
            clen = len;
            if (len > room) begin
                err = ERR_OVERRUN;
            end else if (len == '0) begin
                closed = 1 + close_levels_at(p + 1);
                ps_phase = PH_ID;
            end else if (ps_ident[ID_CONS_BIT]) begin
                if (ps_sp >= MAX_DEPTH) begin
                    err = ERR_DEEP;
                end else begin
                    ps_level_end[ps_sp] = p + 1 + len;
                    ps_sp++;
                    ps_phase = PH_ID;
                end
            end else begin
                ps_elem_end = p + 1 + len;
                ps_phase = PH_CONTENT;
            end
        end

        if (err == ERR_NONE && l && (ps_phase != PH_ID || ps_sp != 0)) err = ERR_TRUNC;
        if (err != ERR_NONE) begin
            hd = 1'b0;
            clen = '0;
            closed = 0;
            ps_failed = 1'b1;
        end
        if (closed > 15) closed = 15;
        ps_pos = (p + 1) & msk;

        r.role      = role;
        r.tag_class = ps_ident[7:6];
        r.cons      = ps_ident[ID_CONS_BIT];
        r.tag       = ps_ident[4:0];
        r.depth     = DEPTH_W'(depth);
        r.hd        = hd;
        r.clen      = clen;
        r.closed    = CLOSE_W'(closed);
        r.err       = err;
        r.buf_end   = l;
        if (l) reset_parser();
        return r;
    endfunction

    // -----------------------------------------------------------------------
    // Buffer generation
    // -----------------------------------------------------------------------

    // Short form, zero-octet long form, or long form with optional padding
    function automatic t_byte_q encode_length(input longint unsigned n);
        t_byte_q q;
        int      octs, k;
        octs = 1;
        for (k = 1; k < 8; k++) if ((n >> (8 * k)) != 0) octs = k + 1;
        if (n == 0 && $urandom_range(0, 3) == 0) begin
            q.push_back(8'h80);
        end else if (n < 128 && $urandom_range(0, 3) != 0) begin
            q.push_back(8'(n));
        end else begin
            if ($urandom_range(0, 4) == 0) octs = $urandom_range(octs, 8);
            q.push_back(8'h80 | 8'(octs));
            for (k = octs - 1; k >= 0; k--) q.push_back(8'(n >> (8 * k)));
        end
        return q;
    endfunction

    function automatic t_byte_q wrap_tlv(input logic [7:0] ident, input t_byte_q body);
        t_byte_q q;
        q = encode_length(64'(body.size()));
        q.push_front(ident);
        foreach (body[i]) q.push_back(body[i]);
        return q;
    endfunction

    function automatic t_byte_q make_element(input int lvl);
        t_byte_q    body, part;
        logic [7:0] ident;
        int         n;
        ident = 8'($urandom);
        if (lvl >= 4 || $urandom_range(0, 2) != 0) begin
            ident[ID_CONS_BIT] = 1'b0;
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 140) : $urandom_range(0, 6);
            repeat (n) body.push_back(8'($urandom));
        end else begin
            ident[ID_CONS_BIT] = 1'b1;
            repeat ($urandom_range(0, 3)) begin
                part = make_element(lvl + 1);
                foreach (part[i]) body.push_back(part[i]);
            end
        end
        return wrap_tlv(ident, body);
    endfunction

    function automatic t_byte_q make_buffer();
        t_byte_q q, part;
        repeat ($urandom_range(1, 3)) begin
            part = make_element(0);
            foreach (part[i]) q.push_back(part[i]);
        end
        return q;
    endfunction

    // Nested constructed elements around one innermost element
    function automatic t_byte_q make_chain(input int levels);
        t_byte_q    q, body;
        logic [7:0] ident;
        ident = 8'($urandom);
        ident[ID_CONS_BIT] = 1'($urandom_range(0, 1));
        if (!ident[ID_CONS_BIT] && $urandom_range(0, 1))
            repeat ($urandom_range(1, 3)) body.push_back(8'($urandom));
        q = wrap_tlv(ident, body);
        repeat (levels) begin
            ident = 8'($urandom);
            ident[ID_CONS_BIT] = 1'b1;
            q = wrap_tlv(ident, q);
        end
        return q;
    endfunction

    function automatic t_byte_q make_broken();
        t_byte_q    q, part;
        logic [7:0] ident;
        int         k;
        case ($urandom_range(0, 4))
            0: begin
                // corrupt one byte
                q = make_buffer();
                q[$urandom_range(0, q.size() - 1)] = 8'($urandom);
            end
            1: begin
                // cut the buffer short
                q = make_buffer();
                k = $urandom_range(1, q.size());
                while (q.size() > k) void'(q.pop_back());
            end
            2: begin
                repeat ($urandom_range(1, 10)) q.push_back(8'($urandom));
            end
            3: begin
                // reserved or oversized length octet count
                q.push_back(8'($urandom));
                q.push_back($urandom_range(0, 1) ? 8'hFF : 8'($urandom_range(8'h89, 8'hFE)));
                repeat ($urandom_range(0, 3)) q.push_back(8'($urandom));
            end
            default: begin
                // parent length shorter than its child
                part = make_element(1);
                ident = 8'($urandom);
                ident[ID_CONS_BIT] = 1'b1;
                q = encode_length(64'($urandom_range(1, part.size() - 1)));
                q.push_front(ident);
                foreach (part[i]) q.push_back(part[i]);
                repeat ($urandom_range(0, 3)) q.push_back(8'($urandom));
            end
        endcase
        return q;
    endfunction

    // -----------------------------------------------------------------------
    // Sender
    // -----------------------------------------------------------------------

    task automatic send_item(input logic [7:0] b, input logic l);
        int gap;
        // Start a new burst, with an idle gap in front of it most times
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= l;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_results.push_back(parse_byte(b, l));
    endtask

    task automatic send_buffer(input t_byte_q q);
        foreach (q[i]) send_item(q[i], i == q.size() - 1);
    endtask

    // Hold the input idle until every expected item has come back
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // -----------------------------------------------------------------------
    // Receiver: stall patterns plus an occasional long hold-off
    // -----------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack    <= hold_req;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            stall_phase <= stall_phase + 1'b1;
            if (stall_phase[5:0] == 6'd0) stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0:       i_out_ready <= 1'b1;
                1:       i_out_ready <= 1'($urandom_range(0, 1));
                2:       i_out_ready <= ($urandom_range(0, 3) == 0);
                default: i_out_ready <= ~(stall_phase[3] & stall_phase[1]);
            endcase
        end
    end

    // -----------------------------------------------------------------------
    // Result checking
    // -----------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("mismatch at result %0d, %s: got %0h, expected %0h",
                     result_count, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            result_count++;
            if (pending_results.size() == 0) begin
                report_mismatch("result with none pending", 64'd0, 64'd0);
            end else begin
                want = pending_results.pop_front();
                check_field("byte_role",      64'(o_byte_role),      64'(want.role));
                check_field("tag_class",      64'(o_tag_class),      64'(want.tag_class));
                check_field("is_constructed", 64'(o_is_constructed), 64'(want.cons));
                check_field("tag_number",     64'(o_tag_number),     64'(want.tag));
                check_field("nest_depth",     64'(o_nest_depth),     64'(want.depth));
                check_field("header_done",    64'(o_header_done),    64'(want.hd));
                check_field("content_length", o_content_length,      want.clen);
                check_field("levels_closed",  64'(o_levels_closed),  64'(want.closed));
                check_field("error_code",     64'(o_error_code),     64'(want.err));
                check_field("buffer_end",     64'(o_buffer_end),     64'(want.buf_end));
            end
        end
    end

    // Abort when neither channel moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[der_tlv_stream_parser] ERROR");
                $finish;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // High tag number with zero-octet long form: an empty element
    task automatic test_header_forms();
        t_byte_q q;
        q = '{8'h3F, 8'h80};
        send_buffer(q);
    endtask

    // Reserved length, too many length octets, all-ones 8-octet length
    task automatic test_length_errors();
        t_byte_q q;
        q = '{8'h02, 8'hFF, 8'h00};
        send_buffer(q);
        q = '{8'h02, 8'h89};
        send_buffer(q);
        q = '{8'h04, 8'h88, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_buffer(q);
    endtask

    // Child content past the parent end, and a child header past it
    task automatic test_overrun();
        t_byte_q q;
        q = '{8'h30, 8'h03, 8'h04, 8'h05, 8'h11};
        send_buffer(q);
        q = '{8'hE1, 8'h01, 8'h04, 8'h00};
        send_buffer(q);
    endtask

    // Buffer ends inside content
    task automatic test_truncation();
        t_byte_q q;
        q = '{8'h04, 8'h02, 8'hAA};
        send_buffer(q);
    endtask

    // Mostly well-formed buffers, some deep chains, the rest broken
    task automatic test_random_stream(input int n_items);
        t_byte_q q;
        int      sent, pick, levels;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 19);
            if (pick < 12) begin
                q = make_buffer();
            end else if (pick < 15) begin
                levels = $urandom_range(0, 1) ? $urandom_range(MAX_DEPTH, MAX_DEPTH + 1)
                                              : $urandom_range(1, MAX_DEPTH - 1);
                q = make_chain(levels);
            end else begin
                q = make_broken();
            end
            send_buffer(q);
            sent += q.size();
        end
    endtask

    // Hold the receiver off while bytes keep coming, then drain fully
    task automatic test_backpressure();
        wait_drain();
        hold_req = hold_req + 1;
        test_random_stream(PRESSURE_ITEMS);
        wait_drain();
    endtask

    initial begin
        reset_parser();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_header_forms();
        test_length_errors();
        test_overrun();
        test_truncation();
        test_random_stream(RANDOM_ITEMS / 2);
        test_backpressure();
        test_random_stream(RANDOM_ITEMS / 2);
        wait_drain();
        if (error_count == 0)
            $display("[der_tlv_stream_parser] OK");
        else
            $display("[der_tlv_stream_parser] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/dtsp_pkg.sv
rtl/core/dtsp_level_stack.sv
rtl/core/dtsp_decode.sv
rtl/core/der_tlv_stream_parser.sv
tb/testbench.sv
